/* sv/pu_pkg.sv */
`default_nettype none

package pu_pkg;

    localparam int TOTAL_W = 7;
    localparam int RANK_W  = 21;
    localparam int PART_W  = 7;
    localparam int CNT_W   = 21;
    localparam int UPC_W   = 4;

    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [RANK_W-1:0]  t_rank;
    typedef logic [PART_W-1:0]  t_part;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [UPC_W-1:0]   t_upc;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_total total;
        t_rank  rank;
    } t_req;

    typedef struct packed {
        t_part   part;
        logic    last;
        t_status status;
    } t_res;

    // datapath action of one control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FILL_INIT,
        OP_FILL_RD,
        OP_FILL_WR,
        OP_ROW_NEXT,
        OP_IDLE,
        OP_CHK_RD,
        OP_WALK_RD,
        OP_WALK_STEP,
        OP_EMIT_ERR,
        OP_EMIT_ZERO
    } t_op;

    // jump condition: taken -> target, else fall through to pc + 1
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_COL_MORE,
        C_ROW_MORE,
        C_NO_START,
        C_BIG,
        C_ZERO,
        C_RANK_OK,
        C_WALK_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uop;

    typedef struct packed {
        logic col_more;
        logic row_more;
        logic big;
        logic zero;
        logic rank_ok;
        logic walk_more;
    } t_flags;

    // microprogram addresses
    localparam t_upc UA_FILL_INIT = 4'd0;
    localparam t_upc UA_FILL_RD   = 4'd1;
    localparam t_upc UA_FILL_WR   = 4'd2;
    localparam t_upc UA_ROW_NEXT  = 4'd3;
    localparam t_upc UA_FILL_DONE = 4'd4;
    localparam t_upc UA_WALK_RD   = 4'd5;
    localparam t_upc UA_WALK_STEP = 4'd6;
    localparam t_upc UA_IDLE      = 4'd7;
    localparam t_upc UA_CHK_RD    = 4'd8;
    localparam t_upc UA_CHK_ZERO  = 4'd9;
    localparam t_upc UA_CHK_RANK  = 4'd10;
    localparam t_upc UA_ERR       = 4'd11;
    localparam t_upc UA_EMPTY     = 4'd12;

    function automatic t_uop ucode(input t_upc pc);
        t_uop w;
        unique case (pc)
            UA_FILL_INIT: w = '{op: OP_FILL_INIT, cond: C_NEXT,      target: UA_FILL_INIT};
            UA_FILL_RD:   w = '{op: OP_FILL_RD,   cond: C_NEXT,      target: UA_FILL_RD};
            UA_FILL_WR:   w = '{op: OP_FILL_WR,   cond: C_COL_MORE,  target: UA_FILL_RD};
            UA_ROW_NEXT:  w = '{op: OP_ROW_NEXT,  cond: C_ROW_MORE,  target: UA_FILL_RD};
            UA_FILL_DONE: w = '{op: OP_NOP,       cond: C_ALWAYS,    target: UA_IDLE};
            UA_WALK_RD:   w = '{op: OP_WALK_RD,   cond: C_NEXT,      target: UA_WALK_RD};
            UA_WALK_STEP: w = '{op: OP_WALK_STEP, cond: C_WALK_MORE, target: UA_WALK_RD};
            UA_IDLE:      w = '{op: OP_IDLE,      cond: C_NO_START,  target: UA_IDLE};
            UA_CHK_RD:    w = '{op: OP_CHK_RD,    cond: C_BIG,       target: UA_ERR};
            UA_CHK_ZERO:  w = '{op: OP_NOP,       cond: C_ZERO,      target: UA_EMPTY};
            UA_CHK_RANK:  w = '{op: OP_NOP,       cond: C_RANK_OK,   target: UA_WALK_RD};
            UA_ERR:       w = '{op: OP_EMIT_ERR,  cond: C_ALWAYS,    target: UA_IDLE};
            UA_EMPTY:     w = '{op: OP_EMIT_ZERO, cond: C_ALWAYS,    target: UA_IDLE};
            default:      w = '{op: OP_NOP,       cond: C_ALWAYS,    target: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/pu_sequencer.sv */
`default_nettype none

module pu_sequencer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire pu_pkg::t_flags i_flags,
    output pu_pkg::t_uop        o_uop,
    output logic                o_busy
);
    import pu_pkg::*;

    t_upc r_pc;
    t_upc n_pc;
    t_uop uop;
    logic take;

    always_comb begin
        uop = ucode(r_pc);
        unique case (uop.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_COL_MORE:  take = i_flags.col_more;
            C_ROW_MORE:  take = i_flags.row_more;
            C_NO_START:  take = !i_start;
            C_BIG:       take = i_flags.big;
            C_ZERO:      take = i_flags.zero;
            C_RANK_OK:   take = i_flags.rank_ok;
            C_WALK_MORE: take = i_flags.walk_more;
            default:     take = 1'b1;
        endcase
        n_pc = take ? uop.target : r_pc + t_upc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_FILL_INIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uop  = uop;
    assign o_busy = (r_pc != UA_IDLE);

endmodule

`default_nettype wire

/* sv/pu_datapath.sv */
`default_nettype none

module pu_datapath #(
    parameter int MAX_N = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire pu_pkg::t_uop i_uop,
    input  wire pu_pkg::t_req i_req,
    output pu_pkg::t_flags    o_flags,
    output logic              o_valid,
    output pu_pkg::t_res      o_res
);
    import pu_pkg::*;

    localparam int SIDE  = MAX_N + 1;
    localparam int DEPTH = SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam t_total TOP = t_total'(MAX_N);
    localparam t_total ONE = t_total'(1);

    t_cnt   r_count_mem [DEPTH];

    t_total r_i, n_i;
    t_total r_j, n_j;
    t_cnt   r_prev, n_prev;
    t_total r_rem, n_rem;
    t_total r_pos, n_pos;
    t_rank  r_k, n_k;
    t_cnt   r_rd;
    logic   r_valid, n_valid;
    t_res   r_res, n_res;

    logic          rd_en;
    logic          wr_en;
    t_total        rd_row, rd_col;
    t_cnt          fill_val;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    function automatic logic [AW-1:0] tab_addr(input t_total row, input t_total col);
        return AW'(row) * AW'(SIDE) + AW'(col);
    endfunction

    // count of partitions of i with every part at least j
    always_comb begin
        if (r_i == '0 || r_j == r_i) begin
            fill_val = t_cnt'(1);
        end else if (r_j > r_i) begin
            fill_val = '0;
        end else begin
            fill_val = r_prev + r_rd;
        end
    end

    always_comb begin
        n_i     = r_i;
        n_j     = r_j;
        n_prev  = r_prev;
        n_rem   = r_rem;
        n_pos   = r_pos;
        n_k     = r_k;
        n_valid = 1'b0;
        n_res   = r_res;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        rd_row  = r_rem - r_pos;
        rd_col  = r_pos;
        unique case (i_uop.op)
            OP_NOP: begin
            end
            OP_FILL_INIT: begin
                n_i    = '0;
                n_j    = TOP;
                n_prev = '0;
            end
            OP_FILL_RD: begin
                rd_en  = 1'b1;
                rd_row = r_i - r_j;
                rd_col = r_j;
            end
            OP_FILL_WR: begin
                // the entry to the right is the one just written: keep it in r_prev
                wr_en  = 1'b1;
                n_prev = fill_val;
                if (r_j != ONE) begin
                    n_j = r_j - ONE;
                end
            end
            OP_ROW_NEXT: begin
                n_i    = r_i + ONE;
                n_j    = TOP;
                n_prev = '0;
            end
            OP_IDLE: begin
                // latch every cycle; only the transfer cycle's value is used
                n_rem = i_req.total;
                n_k   = i_req.rank;
                n_pos = ONE;
            end
            OP_CHK_RD: begin
                rd_en  = 1'b1;
                rd_row = r_rem;
                rd_col = ONE;
            end
            OP_WALK_RD: begin
                rd_en = 1'b1;
            end
            OP_WALK_STEP: begin
                if (r_rd > t_cnt'(r_k)) begin
                    n_valid      = 1'b1;
                    n_res.part   = t_part'(r_pos);
                    n_res.last   = (r_rem == r_pos);
                    n_res.status = ST_OK;
                    n_rem        = r_rem - r_pos;
                end else begin
                    n_k   = r_k - t_rank'(r_rd);
                    n_pos = r_pos + ONE;
                end
            end
            OP_EMIT_ERR: begin
                n_valid      = 1'b1;
                n_res.part   = '0;
                n_res.last   = 1'b1;
                n_res.status = ST_RANGE;
            end
            OP_EMIT_ZERO: begin
                n_valid      = 1'b1;
                n_res.part   = '0;
                n_res.last   = 1'b1;
                n_res.status = (r_k == '0) ? ST_EMPTY : ST_RANGE;
            end
            default: begin
            end
        endcase
    end

    assign rd_addr = tab_addr(rd_row, rd_col);
    assign wr_addr = tab_addr(r_i, r_j);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_count_mem[wr_addr] <= fill_val;
        end
        if (rd_en) begin
            r_rd <= r_count_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_prev <= n_prev;
        r_rem  <= n_rem;
        r_pos  <= n_pos;
        r_k    <= n_k;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_comb begin
        o_flags.col_more  = (r_j != ONE);
        o_flags.row_more  = (r_i != TOP);
        o_flags.big       = (r_rem > TOP);
        o_flags.zero      = (r_rem == '0);
        o_flags.rank_ok   = (t_cnt'(r_k) < r_rd);
        // a taken part that uses up the remainder ends the walk
        o_flags.walk_more = !((r_rd > t_cnt'(r_k)) && (r_rem == r_pos));
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

/* sv/partition_unranker_top.sv */
`default_nettype none

// Channel   Ports                     Transfer
// request   start, i_req, busy        edge with start high and busy low
// result    o_valid, o_res            every edge that ends an o_valid cycle
//
// After reset the count table is built, busy high throughout.
// After its transfer a request runs its checks, then walk steps (a table read, then
// a step) over the one table read port; a walk of total n has at most n steps, and
// busy stays high until the walk ends, so the next request transfers only after it.
// An error or empty request shows its single result.
// Results appear for one cycle each; the receiver cannot stall the block.

module partition_unranker_top #(
    parameter int MAX_N = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire pu_pkg::t_req i_req,
    output logic              busy,
    output logic              o_valid,
    output pu_pkg::t_res      o_res
);
    import pu_pkg::*;

    t_uop   uop;
    t_flags flags;

    pu_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_uop   (uop),
        .o_busy  (busy)
    );

    pu_datapath #(
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uop   (uop),
        .i_req   (i_req),
        .o_flags (flags),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last |-> !busy)
        else $error("final result while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.last |-> busy)
        else $error("non-final result after the walk ended");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status != ST_OK |-> o_res.part == '0 && o_res.last)
        else $error("error or empty result not a single zero part");

    a_part_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.status == ST_OK |->
            o_res.part != '0 && o_res.part <= t_part'(MAX_N))
        else $error("part out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request transfer did not start the walk");

endmodule

`default_nettype wire
